>>> rtl/biquadratic_root_solver_core_macros.svh
// assertion macros for the biquadratic root solver
`ifndef BIQUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH
`define BIQUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// consequent holds in the same cycle as the antecedent
`define BRS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("brs assertion failed");

// consequent holds in the cycle after the antecedent
`define BRS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("brs assertion failed");

`else

`define BRS_ASSERT_NOW(lbl, ante, cons)
`define BRS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> rtl/brs_pkg.sv
`timescale 1ns / 1ps
package brs_pkg;

  localparam int COEF_W    = 16;
  localparam int FRAC_BITS = 16;

  localparam int SD_W    = COEF_W + FRAC_BITS + 1;
  localparam int RAD_W   = 2 * SD_W;
  localparam int NUMU_W  = SD_W + 1;
  localparam int NUM_W   = NUMU_W + 1;
  localparam int DEN_W   = COEF_W + 1;
  localparam int Z_W     = NUMU_W + 1;
  localparam int DISC_W  = 2 * COEF_W + 3;

  localparam int STATUS_W = 2;
  localparam int ROOT_W   = 25;
  localparam int INNER_W  = 40;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_A_ZERO   = 2'd1,
    ST_NEG_DISC = 2'd2
  } status_t;

  typedef struct packed {
    status_t                   status;
    logic signed [COEF_W-1:0]  a;
    logic signed [COEF_W-1:0]  b;
    logic signed [Z_W-1:0]     z1;
    logic signed [Z_W-1:0]     z2;
  } side_t;

endpackage

>>> rtl/brs_in_if.sv
`timescale 1ns / 1ps
interface brs_in_if import brs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] coef_quartic;
  logic signed [COEF_W-1:0] coef_square;
  logic signed [COEF_W-1:0] coef_const;

  modport source (output valid, output coef_quartic, output coef_square,
                  output coef_const, input ready);
  modport sink (input valid, input coef_quartic, input coef_square,
                input coef_const, output ready);
endinterface

>>> rtl/brs_out_if.sv
`timescale 1ns / 1ps
interface brs_out_if import brs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       status;
  logic                      first_real;
  logic [ROOT_W-1:0]         first_root;
  logic signed [INNER_W-1:0] first_inner;
  logic                      second_real;
  logic [ROOT_W-1:0]         second_root;
  logic signed [INNER_W-1:0] second_inner;

  modport source (output valid, output status, output first_real, output first_root,
                  output first_inner, output second_real, output second_root,
                  output second_inner, input ready);
  modport sink (input valid, input status, input first_real, input first_root,
                input first_inner, input second_real, input second_root,
                input second_inner, output ready);
endinterface

>>> rtl/brs_sqrt_pipe.sv
`timescale 1ns / 1ps
module brs_sqrt_pipe import brs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [RAD_W-1:0] rad_i,
  input  side_t            side_i,
  output logic             out_valid,
  output logic [SD_W-1:0]  root_o,
  output side_t            side_o
);

  logic              v_r    [SD_W];
  logic [RAD_W-1:0]  rad_r  [SD_W];
  logic [SD_W+1:0]   rem_r  [SD_W];
  logic [SD_W-1:0]   root_r [SD_W];
  side_t             side_r [SD_W];

  for (genvar s = 0; s < SD_W; s++) begin : g_st
    logic             vi;
    logic [RAD_W-1:0] radi;
    logic [SD_W+1:0]  remi;
    logic [SD_W-1:0]  rooti;
    side_t            sidei;
    logic [SD_W+3:0]  rsh;
    logic [SD_W+3:0]  trial;
    logic [SD_W+3:0]  rdif;
    logic             fit;

    if (s == 0) begin : g_first
      assign vi    = in_valid;
      assign radi  = rad_i;
      assign remi  = '0;
      assign rooti = '0;
      assign sidei = side_i;
    end else begin : g_next
      assign vi    = v_r[s-1];
      assign radi  = rad_r[s-1];
      assign remi  = rem_r[s-1];
      assign rooti = root_r[s-1];
      assign sidei = side_r[s-1];
    end

    assign rsh   = {remi, radi[RAD_W-1 -: 2]};
    assign trial = {2'b00, rooti, 2'b01};
    assign fit   = (rsh >= trial);
    assign rdif  = rsh - trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[s]  <= {radi[RAD_W-3:0], 2'b00};
        rem_r[s]  <= fit ? rdif[SD_W+1:0] : rsh[SD_W+1:0];
        root_r[s] <= {rooti[SD_W-2:0], fit};
        side_r[s] <= sidei;
      end
    end
  end

  assign out_valid = v_r[SD_W-1];
  assign root_o    = root_r[SD_W-1];
  assign side_o    = side_r[SD_W-1];

endmodule

>>> rtl/brs_div_pipe.sv
`timescale 1ns / 1ps
module brs_div_pipe import brs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUMU_W-1:0] num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic              neg_i,
  input  side_t             side_i,
  output logic              out_valid,
  output logic [NUMU_W-1:0] quo_o,
  output logic              neg_o,
  output side_t             side_o
);

  logic              v_r    [NUMU_W];
  logic [NUMU_W-1:0] n_r    [NUMU_W];
  logic [DEN_W-1:0]  rem_r  [NUMU_W];
  logic [DEN_W-1:0]  den_r  [NUMU_W];
  logic              neg_r  [NUMU_W];
  side_t             side_r [NUMU_W];

  for (genvar s = 0; s < NUMU_W; s++) begin : g_st
    logic              vi;
    logic [NUMU_W-1:0] ni;
    logic [DEN_W-1:0]  remi;
    logic [DEN_W-1:0]  deni;
    logic              negi;
    side_t             sidei;
    logic [DEN_W:0]    rsh;
    logic [DEN_W:0]    rdif;
    logic              fit;

    if (s == 0) begin : g_first
      assign vi    = in_valid;
      assign ni    = num_i;
      assign remi  = '0;
      assign deni  = den_i;
      assign negi  = neg_i;
      assign sidei = side_i;
    end else begin : g_next
      assign vi    = v_r[s-1];
      assign ni    = n_r[s-1];
      assign remi  = rem_r[s-1];
      assign deni  = den_r[s-1];
      assign negi  = neg_r[s-1];
      assign sidei = side_r[s-1];
    end

    assign rsh  = {remi, ni[NUMU_W-1]};
    assign fit  = (rsh >= {1'b0, deni});
    assign rdif = rsh - {1'b0, deni};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[s]    <= {ni[NUMU_W-2:0], fit};
        rem_r[s]  <= fit ? rdif[DEN_W-1:0] : rsh[DEN_W-1:0];
        den_r[s]  <= deni;
        neg_r[s]  <= negi;
        side_r[s] <= sidei;
      end
    end
  end

  assign out_valid = v_r[NUMU_W-1];
  assign quo_o     = n_r[NUMU_W-1];
  assign neg_o     = neg_r[NUMU_W-1];
  assign side_o    = side_r[NUMU_W-1];

endmodule

>>> rtl/biquadratic_root_solver_core.sv
`timescale 1ns / 1ps
// Real roots of a*x^4 + b*x^2 + c = 0 for signed coefficient beats. The core takes one
// beat per clock unless the output holds it, and gives one result beat per input beat,
// in order. The pipeline is made of two input stages, a one-bit-per-stage square root
// of the discriminant, two stages that form the signed numerators, a one-bit-per-stage
// divider for both inner roots, a sign stage, a one-bit-per-stage square root of the
// inner roots and the output register. The whole pipeline holds while a result beat
// waits at the output.
`include "biquadratic_root_solver_core_macros.svh"
module biquadratic_root_solver_core import brs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  brs_in_if.sink     in_ch,
  brs_out_if.source  out_ch
);

  logic en;

  // stage 1: products
  logic                       v1_r;
  logic signed [COEF_W-1:0]   a1_r, b1_r;
  logic signed [2*COEF_W-1:0] bb1_r, ac1_r;
  logic signed [2*COEF_W-1:0] bb_nxt, ac_nxt;

  // stage 2: discriminant
  logic                       v2_r;
  side_t                      side2_r;
  logic [RAD_W-1:0]           rad2_r;
  logic signed [DISC_W-1:0]   bbx, acx, disc_nxt;
  status_t                    status_nxt;

  // discriminant square root
  logic                       sq1_v;
  logic [SD_W-1:0]            sq1_root;
  side_t                      sq1_side;

  // stage 3: numerators
  logic                       v3_r;
  side_t                      side3_r;
  logic signed [NUM_W-1:0]    n1_r, n2_r;
  logic signed [NUM_W-1:0]    bx, nb, base, sdx;

  // stage 4: magnitudes
  logic                       v4_r;
  side_t                      side4_r;
  logic [NUMU_W-1:0]          m1_r, m2_r;
  logic [DEN_W-1:0]           dm_r;
  logic                       neg1_r, neg2_r;
  logic signed [NUM_W-1:0]    n1abs, n2abs;
  logic [DEN_W-1:0]           d2, d2neg;

  // dividers
  logic                       dv1_v, dv2_v;
  logic [NUMU_W-1:0]          q1, q2;
  logic                       qn1, qn2;
  side_t                      dv_side;

  // stage 5: signed inner roots
  logic                       v5_r;
  side_t                      side5_r;
  logic [Z_W-1:0]             zq1, zq2;
  logic [RAD_W-1:0]           zr1, zr2;

  // root square roots
  logic                       sr1_v, sr2_v;
  logic [SD_W-1:0]            r1, r2;
  side_t                      sr_side;
  logic [ROOT_W+SD_W-1:0]     r1x, r2x;
  logic [INNER_W+Z_W-1:0]     z1x, z2x;

  // output register
  logic                      out_valid_r;
  logic [STATUS_W-1:0]       out_status_r;
  logic                      out_first_real_r, out_second_real_r;
  logic [ROOT_W-1:0]         out_first_root_r, out_second_root_r;
  logic signed [INNER_W-1:0] out_first_inner_r, out_second_inner_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  assign bb_nxt = in_ch.coef_square * in_ch.coef_square;
  assign ac_nxt = in_ch.coef_quartic * in_ch.coef_const;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
      v2_r <= v1_r;
      v3_r <= sq1_v;
      v4_r <= v3_r;
      v5_r <= dv1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r  <= in_ch.coef_quartic;
      b1_r  <= in_ch.coef_square;
      bb1_r <= bb_nxt;
      ac1_r <= ac_nxt;
    end
  end

  assign bbx      = {{(DISC_W-2*COEF_W){bb1_r[2*COEF_W-1]}}, bb1_r};
  assign acx      = {{(DISC_W-2*COEF_W-2){ac1_r[2*COEF_W-1]}}, ac1_r, 2'b00};
  assign disc_nxt = bbx - acx;

  always_comb begin
    if (a1_r == '0) begin
      status_nxt = ST_A_ZERO;
    end else if (disc_nxt[DISC_W-1]) begin
      status_nxt = ST_NEG_DISC;
    end else begin
      status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side2_r.status <= status_nxt;
      side2_r.a      <= a1_r;
      side2_r.b      <= b1_r;
      side2_r.z1     <= '0;
      side2_r.z2     <= '0;
      rad2_r         <= (status_nxt == ST_OK) ?
                        {1'b0, disc_nxt[2*COEF_W:0], {(2*FRAC_BITS){1'b0}}} : '0;
    end
  end

  brs_sqrt_pipe u_sqrt_disc (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_r),
    .rad_i     (rad2_r),
    .side_i    (side2_r),
    .out_valid (sq1_v),
    .root_o    (sq1_root),
    .side_o    (sq1_side)
  );

  // (-b +/- sqrt(D)) * 2^FRAC_BITS
  assign bx   = {{(NUM_W-COEF_W){sq1_side.b[COEF_W-1]}}, sq1_side.b};
  assign nb   = '0 - bx;
  assign base = {nb[NUM_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
  assign sdx  = {{(NUM_W-SD_W){1'b0}}, sq1_root};

  always_ff @(posedge clk) begin
    if (en) begin
      side3_r <= sq1_side;
      n1_r    <= base + sdx;
      n2_r    <= base - sdx;
    end
  end

  assign n1abs = n1_r[NUM_W-1] ? ('0 - n1_r) : n1_r;
  assign n2abs = n2_r[NUM_W-1] ? ('0 - n2_r) : n2_r;
  assign d2    = {side3_r.a, 1'b0};
  assign d2neg = '0 - d2;

  always_ff @(posedge clk) begin
    if (en) begin
      side4_r <= side3_r;
      m1_r    <= n1abs[NUMU_W-1:0];
      m2_r    <= n2abs[NUMU_W-1:0];
      dm_r    <= side3_r.a[COEF_W-1] ? d2neg : d2;
      neg1_r  <= n1_r[NUM_W-1] ^ side3_r.a[COEF_W-1];
      neg2_r  <= n2_r[NUM_W-1] ^ side3_r.a[COEF_W-1];
    end
  end

  brs_div_pipe u_div_first (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v4_r),
    .num_i     (m1_r),
    .den_i     (dm_r),
    .neg_i     (neg1_r),
    .side_i    (side4_r),
    .out_valid (dv1_v),
    .quo_o     (q1),
    .neg_o     (qn1),
    .side_o    (dv_side)
  );

  brs_div_pipe u_div_second (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v4_r),
    .num_i     (m2_r),
    .den_i     (dm_r),
    .neg_i     (neg2_r),
    .side_i    ('0),
    .out_valid (dv2_v),
    .quo_o     (q2),
    .neg_o     (qn2),
    .side_o    ()
  );

  assign zq1 = {1'b0, q1};
  assign zq2 = {1'b0, q2};

  always_ff @(posedge clk) begin
    if (en) begin
      side5_r.status <= dv_side.status;
      side5_r.a      <= dv_side.a;
      side5_r.b      <= dv_side.b;
      side5_r.z1     <= qn1 ? ('0 - zq1) : zq1;
      side5_r.z2     <= qn2 ? ('0 - zq2) : zq2;
    end
  end

  // z * 2^FRAC_BITS for a non-negative inner root
  assign zr1 = side5_r.z1[Z_W-1] ? '0 :
               {{(RAD_W-NUMU_W-FRAC_BITS){1'b0}}, side5_r.z1[NUMU_W-1:0],
                {FRAC_BITS{1'b0}}};
  assign zr2 = side5_r.z2[Z_W-1] ? '0 :
               {{(RAD_W-NUMU_W-FRAC_BITS){1'b0}}, side5_r.z2[NUMU_W-1:0],
                {FRAC_BITS{1'b0}}};

  brs_sqrt_pipe u_sqrt_first (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .rad_i     (zr1),
    .side_i    (side5_r),
    .out_valid (sr1_v),
    .root_o    (r1),
    .side_o    (sr_side)
  );

  brs_sqrt_pipe u_sqrt_second (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v5_r),
    .rad_i     (zr2),
    .side_i    ('0),
    .out_valid (sr2_v),
    .root_o    (r2),
    .side_o    ()
  );

  assign r1x = {{ROOT_W{1'b0}}, r1};
  assign r2x = {{ROOT_W{1'b0}}, r2};
  assign z1x = {{INNER_W{sr_side.z1[Z_W-1]}}, sr_side.z1};
  assign z2x = {{INNER_W{sr_side.z2[Z_W-1]}}, sr_side.z2};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sr1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_status_r <= sr_side.status;
      if (sr_side.status == ST_OK) begin
        out_first_real_r   <= !sr_side.z1[Z_W-1];
        out_first_root_r   <= r1x[ROOT_W-1:0];
        out_first_inner_r  <= z1x[INNER_W-1:0];
        out_second_real_r  <= !sr_side.z2[Z_W-1];
        out_second_root_r  <= r2x[ROOT_W-1:0];
        out_second_inner_r <= z2x[INNER_W-1:0];
      end else begin
        out_first_real_r   <= 1'b0;
        out_first_root_r   <= '0;
        out_first_inner_r  <= '0;
        out_second_real_r  <= 1'b0;
        out_second_root_r  <= '0;
        out_second_inner_r <= '0;
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.first_real   = out_first_real_r;
  assign out_ch.first_root   = out_first_root_r;
  assign out_ch.first_inner  = out_first_inner_r;
  assign out_ch.second_real  = out_second_real_r;
  assign out_ch.second_root  = out_second_root_r;
  assign out_ch.second_inner = out_second_inner_r;

  // lanes of the paired units stay in step
  `BRS_ASSERT_NOW(a_lanes_aligned, 1'b1, (dv1_v == dv2_v) && (sr1_v == sr2_v))

  // a rejected set carries no roots
  `BRS_ASSERT_NOW(a_reject_zero, out_valid_r && (out_status_r != ST_OK),
    !out_first_real_r && !out_second_real_r && (out_first_root_r == '0) &&
    (out_second_root_r == '0) && (out_first_inner_r == '0) && (out_second_inner_r == '0))

  // a negative inner root has no real roots
  `BRS_ASSERT_NOW(a_neg_no_root, out_valid_r && !out_first_real_r,
    (out_first_root_r == '0) && ((out_status_r != ST_OK) || out_first_inner_r[INNER_W-1]))

  // a held result beat keeps the pipeline frozen
  `BRS_ASSERT_NEXT(a_stall_hold, out_valid_r && !out_ch.ready,
    $stable(v5_r) && $stable(side5_r) && $stable(v2_r))

endmodule

>>> test/tb_biquadratic_root_solver_core.sv
`timescale 1ns / 1ps
module tb_biquadratic_root_solver_core;
  import brs_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 130;

  typedef struct {
    logic signed [COEF_W-1:0] a;
    logic signed [COEF_W-1:0] b;
    logic signed [COEF_W-1:0] c;
  } coef_set_t;

  typedef struct {
    status_t                   status;
    logic                      first_real;
    logic [ROOT_W-1:0]         first_root;
    logic signed [INNER_W-1:0] first_inner;
    logic                      second_real;
    logic [ROOT_W-1:0]         second_root;
    logic signed [INNER_W-1:0] second_inner;
  } roots_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycle_count = 0;
  int   fail_count = 0;
  int   send_idle_pct = 11;
  int   recv_idle_pct = 81;
  int   solved_count = 0;
  int   beat_count = 0;
  coef_set_t pending_sets[$];
  roots_t    expected_roots[$];

  brs_in_if  in_ch ();
  brs_out_if out_ch ();

  biquadratic_root_solver_core uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #1 clk = ~clk;

  // floor(sqrt(v)) digit by digit
  function automatic logic [63:0] floor_sqrt(input logic [127:0] v);
    logic [129:0] rem;
    logic [129:0] trial;
    logic [63:0]  root;
    rem = '0;
    root = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = (rem << 2) | v[2*k +: 2];
      trial = ({66'd0, root} << 2) | 130'd1;
      root = root << 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root[0] = 1'b1;
      end
    end
    return root;
  endfunction

  function automatic roots_t solve_biquadratic(input coef_set_t s);
    roots_t r;
    longint a, b, c, disc, sd, base, den, z1, z2;
    a = s.a;
    b = s.b;
    c = s.c;
    r = '{ST_OK, 1'b0, '0, '0, 1'b0, '0, '0};
    if (a == 0) begin
      r.status = ST_A_ZERO;
      return r;
    end
    disc = b * b - 4 * a * c;
    if (disc < 0) begin
      r.status = ST_NEG_DISC;
      return r;
    end
    sd = longint'(floor_sqrt({64'd0, disc} << (2 * FRAC_BITS)));
    base = -b * (longint'(1) << FRAC_BITS);
    den = 2 * a;
    z1 = (base + sd) / den;
    z2 = (base - sd) / den;
    if (z1 >= 0) begin
      r.first_real = 1'b1;
      r.first_root = ROOT_W'(floor_sqrt({64'd0, z1} << FRAC_BITS));
    end
    if (z2 >= 0) begin
      r.second_real = 1'b1;
      r.second_root = ROOT_W'(floor_sqrt({64'd0, z2} << FRAC_BITS));
    end
    r.first_inner = INNER_W'(z1);
    r.second_inner = INNER_W'(z2);
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.coef_quartic <= '0;
      in_ch.coef_square <= '0;
      in_ch.coef_const <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_roots.push_back(solve_biquadratic(
          '{in_ch.coef_quartic, in_ch.coef_square, in_ch.coef_const}));
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_sets.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid <= 1'b1;
          in_ch.coef_quartic <= pending_sets[0].a;
          in_ch.coef_square <= pending_sets[0].b;
          in_ch.coef_const <= pending_sets[0].c;
          pending_sets.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    roots_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_roots.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          e = expected_roots.pop_front();
          beat_count++;
          if (e.status == ST_OK) solved_count++;
          if (out_ch.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_ch.status);
            fail_count++;
          end
          if (out_ch.first_real !== e.first_real) begin
            $error("first_real: expected %0d, got %0d", e.first_real, out_ch.first_real);
            fail_count++;
          end
          if (out_ch.first_root !== e.first_root) begin
            $error("first_root: expected %0d, got %0d", e.first_root, out_ch.first_root);
            fail_count++;
          end
          if (out_ch.first_inner !== e.first_inner) begin
            $error("first_inner: expected %0d, got %0d", e.first_inner, out_ch.first_inner);
            fail_count++;
          end
          if (out_ch.second_real !== e.second_real) begin
            $error("second_real: expected %0d, got %0d", e.second_real, out_ch.second_real);
            fail_count++;
          end
          if (out_ch.second_root !== e.second_root) begin
            $error("second_root: expected %0d, got %0d", e.second_root, out_ch.second_root);
            fail_count++;
          end
          if (out_ch.second_inner !== e.second_inner) begin
            $error("second_inner: expected %0d, got %0d", e.second_inner,
                   out_ch.second_inner);
            fail_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic add_set(input int a, input int b, input int c);
    pending_sets.push_back('{COEF_W'(a), COEF_W'(b), COEF_W'(c)});
  endtask

  task automatic add_random_sets(input int n);
    int kind;
    int a, c;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        // a and c of opposite sign keep the discriminant non-negative
        a = $urandom_range(32767, 1);
        c = $urandom_range(32767, 0);
        if ($urandom_range(1)) a = -a - ($urandom_range(1) && a == 32767);
        else c = -c;
        add_set(a, $urandom, c);
      end else if (kind < 70) begin
        add_set($signed($urandom_range(20)) - 10, $signed($urandom_range(200)) - 100,
                $signed($urandom_range(200)) - 100);
      end else if (kind < 77) begin
        add_set(0, $urandom, $urandom);
      end else begin
        add_set($urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic wait_all_done();
    while (pending_sets.size() > 0 || in_ch.valid || expected_roots.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // zero leading coefficient
    add_set(0, 0, 0);
    add_set(0, -32768, 32767);
    // negative discriminant
    add_set(1, 0, 1);
    add_set(32767, 0, 32767);
    add_set(-32768, 0, -32768);
    // zero discriminant and zero roots
    add_set(1, 0, 0);
    add_set(1, -2, 1);
    add_set(-1, 0, 0);
    // extremes
    add_set(-32768, -32768, 32767);
    add_set(-32768, 32767, 32767);
    add_set(32767, -32768, -32768);
    add_set(32767, 32767, -32768);
    add_set(1, -32768, -32768);
    add_set(-1, 32767, 32767);
    add_set(1, 32767, -32768);
    add_set(-32768, -32768, 0);
    add_set(-32768, 1, 0);
    // both inner roots negative, both positive, mixed
    add_set(1, 5, 6);
    add_set(1, -5, 6);
    add_set(1, 0, -4);
    // tiny negative inner root
    add_set(32767, 1, 0);
    add_set(-32768, -1, 0);
    add_set(3, 1, -1);
    add_random_sets(540);
    wait_all_done();

    send_idle_pct = 81;
    recv_idle_pct = 11;
    add_random_sets(570);
    wait_all_done();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_sets(570);
    wait_all_done();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d result beats, %0d solved, over three handshake idling mixes",
             beat_count, solved_count);
    if (fail_count == 0 && expected_roots.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
